### src/tpbt_pkg.sv
package tpbt_pkg;

  localparam int unsigned POS_BITS_DEFAULT = 32;
  localparam int unsigned RES_FIFO_DEPTH   = 4;

  localparam int unsigned CFG_DATA_BITS = 10;

  // register indexes
  localparam logic CFG_CHARS_PER_LINE = 1'b0;
  localparam logic CFG_LINES_PER_PAGE = 1'b1;

  // item kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // character classes
  localparam logic [2:0] CLS_NEWLINE = 3'd0;
  localparam logic [2:0] CLS_SPACE   = 3'd1;
  localparam logic [2:0] CLS_HYPHEN  = 3'd2;
  localparam logic [2:0] CLS_PUNCT   = 3'd3;
  localparam logic [2:0] CLS_LETTER  = 3'd4;
  localparam logic [2:0] CLS_OTHER   = 3'd5;

  localparam logic [9:0] CHARS_PER_LINE_RESET = 10'd40;
  localparam logic [7:0] LINES_PER_PAGE_RESET = 8'd20;

  typedef struct packed {
    logic        kind;
    logic [2:0]  char_class;
    logic [31:0] position;
  } tpbt_in_t;

  typedef struct packed {
    logic [15:0] page_slot;
    logic [31:0] page_offset;
    logic        last;
  } tpbt_out_t;

  // results of one item handed to the result queue
  typedef struct packed {
    logic [1:0] cnt;
    tpbt_out_t  res0;
    tpbt_out_t  res1;
  } tpbt_push_t;

endpackage

### src/text_page_break_tracker_top.sv
// Page break tracker: takes classified characters with their byte offsets and writes
// page table entries (slot, start offset) as pages fill, plus an end entry when an end
// item arrives. An item is taken every cycle while the result queue has room for two
// entries; an accepted item is held in an input register, then its results are queued.
// A character item gives at most one entry, an end item up to two, output in turn.
// The four-entry result queue lets new items enter while earlier entries wait.
module text_page_break_tracker_top #(
  parameter int unsigned POS_BITS = tpbt_pkg::POS_BITS_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic                               cfg_index_i,
  input  logic [tpbt_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  tpbt_pkg::tpbt_in_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output tpbt_pkg::tpbt_out_t                out_data_o
);
  import tpbt_pkg::*;

  logic       in_valid_q, in_valid_d;
  tpbt_in_t   in_q;
  logic       room;
  logic       go;
  logic       accept;
  tpbt_push_t push;

  assign go         = in_valid_q && room;
  assign in_stall_o = in_valid_q && !room;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_valid_d = accept ? 1'b1 : (go ? 1'b0 : in_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  tpbt_core #(
    .POS_BITS(POS_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .go_i       (go),
    .item_i     (in_q),
    .push_o     (push)
  );

  tpbt_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

### src/tpbt_fifo.sv
module tpbt_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tpbt_pkg::tpbt_push_t push_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tpbt_pkg::tpbt_out_t out_data_o
);
  import tpbt_pkg::*;

  localparam int unsigned PtrBits = $clog2(RES_FIFO_DEPTH);
  localparam int unsigned CntBits = $clog2(RES_FIFO_DEPTH + 1);

  tpbt_out_t           mem_q [RES_FIFO_DEPTH];
  logic [PtrBits-1:0]  wr_ptr_q, wr_ptr_d, wr_ptr_p1;
  logic [PtrBits-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0]  count_q, count_d;
  logic                pop;

  assign pop         = (count_q != '0) && !out_stall_i;
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  // room for the two results an end item can write
  assign room_o      = (count_q <= CntBits'(RES_FIFO_DEPTH - 2));
  assign wr_ptr_p1   = wr_ptr_q + PtrBits'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrBits'(push_i.cnt);
    rd_ptr_d = pop ? rd_ptr_q + PtrBits'(1) : rd_ptr_q;
    count_d  = count_q + CntBits'(push_i.cnt) - CntBits'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_p1] <= push_i.res1;
    end
  end

endmodule

### src/tpbt_core.sv
module tpbt_core #(
  parameter int unsigned POS_BITS = tpbt_pkg::POS_BITS_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [tpbt_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                          go_i,
  input  tpbt_pkg::tpbt_in_t            item_i,
  output tpbt_pkg::tpbt_push_t          push_o
);
  import tpbt_pkg::*;

  logic [9:0]          cpl_q;
  logic [7:0]          lpp_q;
  logic [15:0]         cc_q, cc_d;
  logic [7:0]          lc_q, lc_d;
  logic [POS_BITS-1:0] ws_q, ws_d;
  logic [15:0]         pc_q, pc_d;

  logic [POS_BITS-1:0] pos;
  logic [POS_BITS-1:0] diff;
  logic [15:0]         span;
  logic [16:0]         cc_sum;
  logic [15:0]         cc_inc;
  logic                full;
  logic [7:0]          lc_bump;
  logic [7:0]          lc_pre;
  logic [POS_BITS-1:0] chk_off;
  logic                do_check;
  tpbt_push_t          push;

  assign pos     = POS_BITS'(item_i.position);
  assign diff    = pos - ws_q;
  assign span    = (diff > POS_BITS'(16'hFFFF)) ? 16'hFFFF : diff[15:0];
  assign cc_sum  = {1'b0, cc_q} + 17'd1;
  assign cc_inc  = cc_sum[16] ? 16'hFFFF : cc_sum[15:0];
  assign full    = (cc_inc >= {6'd0, cpl_q});
  assign lc_bump = (lc_q == 8'hFF) ? 8'hFF : lc_q + 8'd1;

  always_comb begin
    cc_d     = cc_q;
    lc_pre   = lc_q;
    ws_d     = ws_q;
    pc_d     = pc_q;
    chk_off  = pos;
    do_check = 1'b0;
    push     = '0;
    lc_d     = lc_q;

    if (item_i.kind == KIND_END) begin
      if ((cc_q != 16'd0) || (lc_q != 8'd0)) begin
        push.cnt  = 2'd2;
        push.res0 = '{page_slot: pc_q, page_offset: 32'(pos), last: 1'b0};
        push.res1 = '{page_slot: pc_q + 16'd1, page_offset: 32'(pos), last: 1'b1};
      end else begin
        push.cnt  = 2'd1;
        push.res0 = '{page_slot: pc_q, page_offset: 32'(pos), last: 1'b1};
      end
      cc_d = '0;
      lc_d = '0;
      ws_d = '0;
      pc_d = '0;
    end else begin
      unique case (item_i.char_class)
        CLS_NEWLINE: begin
          lc_pre   = lc_bump;
          do_check = 1'b1;
        end
        CLS_SPACE: begin
          ws_d     = pos;
          cc_d     = full ? 16'd0 : cc_inc;
          lc_pre   = full ? lc_bump : lc_q;
          do_check = 1'b1;
        end
        CLS_HYPHEN, CLS_PUNCT: begin
          if (cc_q == 16'd0) begin
            // punctuation at line start pulls the last word down
            if ((lc_q == 8'd0) && (pc_q != 16'd0)) begin
              push.cnt  = 2'd1;
              push.res0 = '{page_slot: pc_q - 16'd1, page_offset: 32'(ws_q), last: 1'b1};
            end
            cc_d = span;
            if (item_i.char_class == CLS_PUNCT) begin
              ws_d = pos;
            end
          end else begin
            cc_d     = full ? 16'd0 : cc_inc;
            lc_pre   = full ? lc_bump : lc_q;
            do_check = 1'b1;
          end
        end
        CLS_LETTER: begin
          // a letter that fills the line carries its word over
          cc_d     = full ? span : cc_inc;
          lc_pre   = full ? lc_bump : lc_q;
          chk_off  = ws_q;
          do_check = 1'b1;
        end
        default: begin
          cc_d     = full ? 16'd0 : cc_inc;
          lc_pre   = full ? lc_bump : lc_q;
          chk_off  = ws_q;
          do_check = 1'b1;
        end
      endcase

      lc_d = lc_pre;
      if (do_check && (lc_pre >= lpp_q)) begin
        lc_d      = 8'd0;
        push.cnt  = 2'd1;
        push.res0 = '{page_slot: pc_q, page_offset: 32'(chk_off), last: 1'b1};
        pc_d      = pc_q + 16'd1;
      end
    end
  end

  always_comb begin
    push_o = push;
    if (!go_i) begin
      push_o.cnt = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpl_q <= CHARS_PER_LINE_RESET;
      lpp_q <= LINES_PER_PAGE_RESET;
      cc_q  <= '0;
      lc_q  <= '0;
      ws_q  <= '0;
      pc_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_CHARS_PER_LINE: cpl_q <= cfg_data_i[9:0];
          CFG_LINES_PER_PAGE: lpp_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (go_i) begin
        cc_q <= cc_d;
        lc_q <= lc_d;
        ws_q <= ws_d;
        pc_q <= pc_d;
      end
    end
  end

endmodule
